/* src/priority_task_table_defines.svh */
// ----------------------------------------------------------------------------
// priority_task_table_defines
// assertion macros of the priority task table rtl
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_TABLE_DEFINES_SVH
`define PRIORITY_TASK_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define PTT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// checked on every edge, reset included
`define PTT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define PTT_ASSERT(lbl, prop)
`define PTT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* src/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// types and constants of the priority task table
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  localparam int unsigned TASK_SLOTS    = 1024;
  localparam int unsigned IDX_BITS      = $clog2(TASK_SLOTS);
  localparam int unsigned ID_BITS       = 10;
  localparam int unsigned OWNER_BITS    = 16;
  localparam int unsigned PRIORITY_BITS = 32;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_EDIT   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_EXEC   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [OWNER_BITS-1:0]      user_id;
    logic [ID_BITS-1:0]         task_id;
    logic [PRIORITY_BITS-1:0]   priority_req;
  } item_t;

  typedef struct packed {
    logic                  found;
    logic [OWNER_BITS-1:0] owner_out;
  } result_t;

  typedef struct packed {
    logic                     live;
    logic [OWNER_BITS-1:0]    owner;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_EXEC
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_ADD,
    WR_REMOVE,
    WR_EDIT,
    WR_TAKE
  } wr_op_t;

  typedef enum logic {
    RD_ITEM,
    RD_CNT
  } rd_sel_t;

  typedef struct packed {
    logic    cnt_clr;
    logic    cnt_inc;
    rd_sel_t rd_sel;
    logic    scan_rd;
    logic    scan_init;
    logic    req_load;
    logic    emit;
    wr_op_t  wr_op;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
  } status_t;

endpackage

`default_nettype wire

/* src/priority_task_table.sv */
// ----------------------------------------------------------------------------
// priority_task_table
// indexed table of live tasks with add, edit, remove and execute-top
// ----------------------------------------------------------------------------
// an item is taken on a rising edge with start high and busy low. add and
// remove are done in the accept cycle, busy stays low; edit reads the slot
// and writes it back, so busy is high for one cycle. execute-top sweeps all
// TASK_SLOTS slots through the single read port of the task memory, one slot
// a cycle, then clears the winner: busy stays high through the sweep, the
// compare of the last slot and the clearing write; the transaction appears
// on result with done high for one cycle right after busy falls. the
// receiver cannot stall, so result must be captured on that edge. after
// reset the memory is swept clean, one slot a cycle, with busy held high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_task_table_defines.svh"

module priority_task_table (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire ptt_pkg::item_t   item,
  output logic                  busy,
  output logic                  done,
  output ptt_pkg::result_t      result
);

  ptt_pkg::cmd_t    cmd;
  ptt_pkg::status_t status;
  logic             accept;

  // transaction handshake
  assign accept = start && !busy;

  // sequencer
  ptt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (item.kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // memory, scan compare and result register
  ptt_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result),
    .done   (done)
  );

  // clearing pass holds off transactions straight after reset
  `PTT_ASSERT_ALWAYS(a_busy_after_reset, rst |=> busy)
  // an execute-top keeps the block busy while it scans
  `PTT_ASSERT(a_exec_goes_busy, accept && item.kind == ptt_pkg::KIND_EXEC |=> busy)
  // results are single-cycle strobes, never back to back
  `PTT_ASSERT(a_done_single, done |=> !done)
  // empty table reports a zero owner
  `PTT_ASSERT(a_empty_owner_zero, done && !result.found |-> result.owner_out == '0)
  // a result only follows a finished scan
  `PTT_ASSERT(a_done_after_busy, done |-> $past(busy))

endmodule

`default_nettype wire

/* src/ptt_ctrl.sv */
// ----------------------------------------------------------------------------
// ptt_ctrl
// sequencer: clearing pass, edit read-modify-write and execute-top scan
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire ptt_pkg::kind_t   kind,
  input  wire ptt_pkg::status_t status,
  output ptt_pkg::cmd_t         cmd,
  output logic                  busy
);

  ptt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.rd_sel    = ptt_pkg::RD_ITEM;
    cmd.wr_op     = ptt_pkg::WR_NONE;
    busy          = 1'b1;
    case (state)
      ptt_pkg::ST_CLEAR: begin
        cmd.wr_op   = ptt_pkg::WR_CLEAR;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_last) begin
          state_next = ptt_pkg::ST_IDLE;
        end
      end
      ptt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          case (kind)
            ptt_pkg::KIND_ADD:    cmd.wr_op = ptt_pkg::WR_ADD;
            ptt_pkg::KIND_REMOVE: cmd.wr_op = ptt_pkg::WR_REMOVE;
            ptt_pkg::KIND_EDIT: begin
              // read of the slot goes out now, write-back next cycle
              cmd.req_load = 1'b1;
              state_next   = ptt_pkg::ST_EDIT;
            end
            ptt_pkg::KIND_EXEC: begin
              cmd.cnt_clr   = 1'b1;
              cmd.scan_init = 1'b1;
              state_next    = ptt_pkg::ST_SCAN;
            end
            default: state_next = ptt_pkg::ST_IDLE;
          endcase
        end
      end
      ptt_pkg::ST_EDIT: begin
        cmd.wr_op  = ptt_pkg::WR_EDIT;
        state_next = ptt_pkg::ST_IDLE;
      end
      ptt_pkg::ST_SCAN: begin
        cmd.rd_sel  = ptt_pkg::RD_CNT;
        cmd.scan_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_last) begin
          state_next = ptt_pkg::ST_SCAN_END;
        end
      end
      ptt_pkg::ST_SCAN_END: begin
        // last slot is compared in this cycle
        state_next = ptt_pkg::ST_EXEC;
      end
      ptt_pkg::ST_EXEC: begin
        cmd.wr_op  = ptt_pkg::WR_TAKE;
        cmd.emit   = 1'b1;
        state_next = ptt_pkg::ST_IDLE;
      end
      default: state_next = ptt_pkg::ST_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

/* src/ptt_datapath.sv */
// ----------------------------------------------------------------------------
// ptt_datapath
// task memory, slot counter, running best of the scan and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ptt_pkg::item_t   item,
  input  wire ptt_pkg::cmd_t    cmd,
  output ptt_pkg::status_t      status,
  output ptt_pkg::result_t      result,
  output logic                  done
);

  ptt_pkg::entry_t mem [ptt_pkg::TASK_SLOTS];
  ptt_pkg::entry_t rd_data;
  ptt_pkg::entry_t wr_data;
  ptt_pkg::item_t  req;

  logic [ptt_pkg::IDX_BITS-1:0]      cnt;
  logic [ptt_pkg::IDX_BITS-1:0]      rd_addr;
  logic [ptt_pkg::IDX_BITS-1:0]      wr_addr;
  logic                              wr_en;
  logic                              item_id_ok;
  logic                              req_id_ok;
  logic                              cmp_en;
  logic [ptt_pkg::IDX_BITS-1:0]      cmp_idx;
  logic                              have;
  logic [ptt_pkg::IDX_BITS-1:0]      best_idx;
  logic [ptt_pkg::OWNER_BITS-1:0]    best_owner;
  logic [ptt_pkg::PRIORITY_BITS-1:0] best_prio;
  logic                              take;

  assign item_id_ok = 32'(item.task_id) < ptt_pkg::TASK_SLOTS;
  assign req_id_ok  = 32'(req.task_id) < ptt_pkg::TASK_SLOTS;

  assign status.cnt_last = cnt == ptt_pkg::IDX_BITS'(ptt_pkg::TASK_SLOTS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req <= item;
    end
  end

  assign rd_addr = (cmd.rd_sel == ptt_pkg::RD_CNT) ? cnt
                                                   : ptt_pkg::IDX_BITS'(item.task_id);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptt_pkg::IDX_BITS'(item.task_id);
    wr_data = '0;
    case (cmd.wr_op)
      ptt_pkg::WR_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt;
      end
      ptt_pkg::WR_ADD: begin
        wr_en   = item_id_ok;
        wr_data = '{live: 1'b1, owner: item.user_id, prio: item.priority_req};
      end
      ptt_pkg::WR_REMOVE: begin
        wr_en = item_id_ok;
      end
      ptt_pkg::WR_EDIT: begin
        // only a live slot takes the new priority
        wr_en   = req_id_ok && rd_data.live;
        wr_addr = ptt_pkg::IDX_BITS'(req.task_id);
        wr_data = '{live: 1'b1, owner: rd_data.owner, prio: req.priority_req};
      end
      ptt_pkg::WR_TAKE: begin
        wr_en   = have;
        wr_addr = best_idx;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // compare stage, one slot behind the read
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_rd;
    end
    cmp_idx <= cnt;
  end

  // later slot wins a tie, as the scan runs upwards
  assign take = cmp_en && rd_data.live && (!have || rd_data.prio >= best_prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.scan_init) begin
      have <= 1'b0;
    end else if (take) begin
      have <= 1'b1;
    end
    if (take) begin
      best_idx   <= cmp_idx;
      best_owner <= rd_data.owner;
      best_prio  <= rd_data.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      result.found     <= have;
      result.owner_out <= have ? best_owner : '0;
    end
  end

endmodule

`default_nettype wire

/* verif/priority_task_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_task_table_tb
// self-checking bench for the priority task table
// ----------------------------------------------------------------------------
// a model of the task table is updated on every accepted transaction. each
// execute-top queues the owner that the model expects, and the result strobe
// is checked against the oldest entry in that queue. a directed part covers
// the extremes, every operation, absent tasks, the empty table, ties and
// unsigned priority order. a random part follows, in bursts with idle gaps,
// most ids drawn from a small pool so that edits and removes hit live tasks.
// ----------------------------------------------------------------------------

module priority_task_table_tb;

  localparam int unsigned RANDOM_ITEMS = 556;
  // execute-top keeps busy high through a full sweep of the table, as does the
  // reset clearing sweep; allow several of those with no transaction
  localparam int unsigned QUIET_LIMIT  = 4 * (ptt_pkg::TASK_SLOTS + 2) + 64;

  // model of the table: live flags, owners, priorities, and the owners that
  // pending execute-top transactions are due to return
  class task_table_model;
    bit                                live [ptt_pkg::TASK_SLOTS];
    logic [ptt_pkg::OWNER_BITS-1:0]    owner [ptt_pkg::TASK_SLOTS];
    logic [ptt_pkg::PRIORITY_BITS-1:0] prio [ptt_pkg::TASK_SLOTS];
    ptt_pkg::result_t                  due_q [$];
    int unsigned                       mismatches;
    int unsigned                       taken;
    int unsigned                       found_cnt;
    int unsigned                       empty_cnt;

    function void note(ptt_pkg::item_t it);
      int unsigned                       i;
      int unsigned                       top;
      bit                                have;
      logic [ptt_pkg::PRIORITY_BITS-1:0] top_prio;
      ptt_pkg::result_t                  r;
      taken++;
      case (it.kind)
        ptt_pkg::KIND_ADD: begin
          owner[it.task_id] = it.user_id;
          prio[it.task_id]  = it.priority_req;
          live[it.task_id]  = 1'b1;
        end
        ptt_pkg::KIND_EDIT: begin
          if (live[it.task_id])
            prio[it.task_id] = it.priority_req;
        end
        ptt_pkg::KIND_REMOVE: begin
          live[it.task_id] = 1'b0;
        end
        ptt_pkg::KIND_EXEC: begin
          have     = 1'b0;
          top      = 0;
          top_prio = '0;
          // ascending sweep, >= lets the larger id win a tie
          for (i = 0; i < ptt_pkg::TASK_SLOTS; i++) begin
            if (live[i] && (!have || prio[i] >= top_prio)) begin
              have     = 1'b1;
              top      = i;
              top_prio = prio[i];
            end
          end
          r.found     = have;
          r.owner_out = have ? owner[top] : '0;
          if (have)
            live[top] = 1'b0;
          due_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check(ptt_pkg::result_t got);
      ptt_pkg::result_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        $error("result with no execute-top waiting: found %0d owner_out %h",
               got.found, got.owner_out);
        return;
      end
      want = due_q.pop_front();
      if (got.found !== want.found) begin
        mismatches++;
        $error("found: expected %0d, actual %0d", want.found, got.found);
      end
      if (got.owner_out !== want.owner_out) begin
        mismatches++;
        $error("owner_out: expected %h, actual %h", want.owner_out, got.owner_out);
      end
      if (want.found)
        found_cnt++;
      else
        empty_cnt++;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  ptt_pkg::item_t   item  = '0;
  logic             busy;
  logic             done;
  ptt_pkg::result_t result;

  task_table_model table_model;
  int unsigned     id_pool [16];
  int unsigned     quiet = 0;

  priority_task_table DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: results first, then the transaction taken on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        table_model.check(result);
      if (start && !busy)
        table_model.note(item);
    end
  end

  // watchdog on cycles with neither a transaction nor a result
  always @(posedge clk) begin
    if (rst || done || (start && !busy))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $error("no transaction or result for %0d cycles", quiet);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic ptt_pkg::item_t make_item(ptt_pkg::kind_t k,
                                               logic [ptt_pkg::OWNER_BITS-1:0] user,
                                               logic [ptt_pkg::ID_BITS-1:0] id,
                                               logic [ptt_pkg::PRIORITY_BITS-1:0] p);
    ptt_pkg::item_t it;
    it.kind         = k;
    it.user_id      = user;
    it.task_id      = id;
    it.priority_req = p;
    return it;
  endfunction

  // dense small values for ties, some extremes, some full range
  function automatic logic [ptt_pkg::PRIORITY_BITS-1:0] rand_priority();
    logic [ptt_pkg::PRIORITY_BITS-1:0] p;
    case ($urandom_range(0, 4))
      0, 1: p = $urandom_range(0, 3);
      2: begin
        case ($urandom_range(0, 3))
          0: p = '1;
          1: p = '0;
          2: p = 32'h8000_0000;
          default: p = 32'h7FFF_FFFF;
        endcase
      end
      default: p = $urandom();
    endcase
    return p;
  endfunction

  // ignored fields are random too, so every input bit moves
  function automatic ptt_pkg::item_t random_item();
    ptt_pkg::item_t it;
    int unsigned    pick;
    it.user_id      = ptt_pkg::OWNER_BITS'($urandom_range(0, 65535));
    it.priority_req = rand_priority();
    if ($urandom_range(0, 3) != 0)
      it.task_id = ptt_pkg::ID_BITS'(id_pool[$urandom_range(0, 15)]);
    else
      it.task_id = ptt_pkg::ID_BITS'($urandom_range(0, ptt_pkg::TASK_SLOTS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 40)
      it.kind = ptt_pkg::KIND_ADD;
    else if (pick < 60)
      it.kind = ptt_pkg::KIND_EDIT;
    else if (pick < 75)
      it.kind = ptt_pkg::KIND_REMOVE;
    else
      it.kind = ptt_pkg::KIND_EXEC;
    return it;
  endfunction

  // raise start with the transaction and hold until busy is low on an edge;
  // returns on the accepting edge with start still high
  task automatic send(input ptt_pkg::item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic directed_part();
    // empty table, then absent edit and remove
    send(make_item(ptt_pkg::KIND_EXEC,   16'h0000, 10'd0,    32'h0));
    send(make_item(ptt_pkg::KIND_EDIT,   16'h1111, 10'd5,    32'h9));
    send(make_item(ptt_pkg::KIND_REMOVE, 16'h2222, 10'd6,    32'h0));
    // extremes of id, owner and priority; equal top priority, larger id wins
    send(make_item(ptt_pkg::KIND_ADD,    16'h0000, 10'd0,    32'h0));
    send(make_item(ptt_pkg::KIND_ADD,    16'hFFFF, 10'd1023, 32'hFFFF_FFFF));
    send(make_item(ptt_pkg::KIND_ADD,    16'h1234, 10'd512,  32'hFFFF_FFFF));
    send(make_item(ptt_pkg::KIND_EXEC,   16'hFFFF, 10'd1023, 32'hFFFF_FFFF));
    send(make_item(ptt_pkg::KIND_EXEC,   16'h0000, 10'd0,    32'h0));
    send(make_item(ptt_pkg::KIND_EXEC,   16'h0000, 10'd0,    32'h0));
    send(make_item(ptt_pkg::KIND_EXEC,   16'h0000, 10'd0,    32'h0));
    // overwrite of a live id, edit of a live task, tie at priority zero
    send(make_item(ptt_pkg::KIND_ADD,    16'hAAAA, 10'd7,    32'd10));
    send(make_item(ptt_pkg::KIND_ADD,    16'h5555, 10'd7,    32'd20));
    send(make_item(ptt_pkg::KIND_ADD,    16'h0F0F, 10'd3,    32'd15));
    send(make_item(ptt_pkg::KIND_EDIT,   16'h0000, 10'd3,    32'd30));
    send(make_item(ptt_pkg::KIND_EXEC,   16'h0000, 10'd0,    32'h0));
    send(make_item(ptt_pkg::KIND_EDIT,   16'hFFFF, 10'd7,    32'd0));
    send(make_item(ptt_pkg::KIND_ADD,    16'h8001, 10'd9,    32'd0));
    send(make_item(ptt_pkg::KIND_EXEC,   16'h0000, 10'd0,    32'h0));
    send(make_item(ptt_pkg::KIND_REMOVE, 16'h0000, 10'd7,    32'h0));
    send(make_item(ptt_pkg::KIND_EXEC,   16'h0000, 10'd0,    32'h0));
    // priority compares unsigned: msb set beats everything below it
    send(make_item(ptt_pkg::KIND_ADD,    16'h1111, 10'd2,    32'h8000_0000));
    send(make_item(ptt_pkg::KIND_ADD,    16'h2222, 10'd4,    32'h7FFF_FFFF));
    send(make_item(ptt_pkg::KIND_EXEC,   16'h0000, 10'd0,    32'h0));
    send(make_item(ptt_pkg::KIND_EXEC,   16'h0000, 10'd0,    32'h0));
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned directed_cnt;
    int unsigned k;
    bit          drained;
    table_model = new;
    // pool of ids that most random transactions hit, extremes included
    id_pool[0] = 0;
    id_pool[1] = ptt_pkg::TASK_SLOTS - 1;
    for (k = 2; k < 16; k++)
      id_pool[k] = $urandom_range(0, ptt_pkg::TASK_SLOTS - 1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // the clearing sweep after reset simply holds off the first transaction
    directed_part();
    directed_cnt = table_model.taken;

    // random bursts separated by idle gaps; now and then a long burst with
    // no idling at all
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send(random_item());
        sent++;
      end
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      // once, halfway, hold off until every execute-top has answered
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        while (table_model.pending() != 0) @(posedge clk);
        drained = 1'b1;
      end
    end

    // drain, then leave room for a stray result of a full sweep
    do @(posedge clk); while (table_model.pending() != 0);
    repeat (ptt_pkg::TASK_SLOTS + 8) @(posedge clk);
    if (table_model.pending() != 0) begin
      table_model.mismatches++;
      $error("%0d execute-top results never arrived", table_model.pending());
    end

    $display("%0d transactions (%0d directed, %0d random)", table_model.taken,
             directed_cnt, table_model.taken - directed_cnt);
    $display("%0d execute-top results: %0d returned an owner, %0d on an empty table",
             table_model.found_cnt + table_model.empty_cnt, table_model.found_cnt,
             table_model.empty_cnt);
    if (table_model.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
